// ===== design/lph_pkg.sv =====
// Shared types, sizes and codes for the linear probing hash table.
package lph_pkg;

  localparam int TABLE_SLOTS = 512;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // Fixed field widths of the item ports
  localparam int HOME_BITS   = 9;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                 action;
    logic [KEY_W-1:0]     key_token;
    logic [HOME_BITS-1:0] home_slot;
    logic [VAL_W-1:0]     entry_value;
    logic                 value_present;
  } lph_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HOME_BITS-1:0] slot_used;
    logic [VAL_W-1:0]     found_value;
    logic                 has_value;
  } lph_rsp_t;

  typedef struct packed {
    logic                  occ;
    logic                  present;
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   key;
  } lph_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       reduce;
    logic       rd_home;
    logic       rd_next;
    logic       wr_entry;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_hit;
  } lph_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic home_ge;
    logic action;
    logic occ;
    logic key_eq;
    logic cnt_last;
  } lph_sts_t;

endpackage

// ===== design/lph_ctrl.sv =====
// Sequencer for clearing, home slot reduction and slot probing.
module lph_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lph_pkg::lph_sts_t sts_i,
  output lph_pkg::lph_cmd_t cmd_o,
  output logic              busy_o
);
  import lph_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HOME  = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HOME;
        end
      end
      S_HOME: begin
        // fold an out-of-range home slot, then read it
        if (sts_i.home_ge) begin
          cmd_o.reduce = 1'b1;
        end else begin
          cmd_o.rd_home = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.action == ACT_INSERT) begin
          priority if (!sts_i.occ) begin
            cmd_o.wr_entry    = 1'b1;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_OK;
            state_d           = S_IDLE;
          end else if (sts_i.cnt_last) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_FULL;
            state_d           = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end else begin
          priority if (!sts_i.occ) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_MISS;
            state_d           = S_IDLE;
          end else if (sts_i.key_eq) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_OK;
            cmd_o.emit_hit    = 1'b1;
            state_d           = S_IDLE;
          end else if (sts_i.cnt_last) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_MISS;
            state_d           = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== design/lph_dp.sv =====
// Slot memory, probe pointer, item registers and result register.
module lph_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lph_pkg::lph_cmd_t cmd_i,
  input  lph_pkg::lph_req_t req_i,
  output lph_pkg::lph_sts_t sts_o,
  output logic              valid_o,
  output lph_pkg::lph_rsp_t rsp_o
);
  import lph_pkg::*;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

  lph_entry_t mem [TABLE_SLOTS];

  logic                  act_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  pres_q;
  logic [HOME_BITS-1:0]  home_q;
  logic [SLOT_BITS-1:0]  slot_q, cnt_q, clr_q;
  logic [SLOT_BITS-1:0]  slot_next, rd_addr, wr_addr;
  lph_entry_t            rd_q, wr_data;
  logic                  rd_en, wr_en;
  logic                  valid_q;
  lph_rsp_t              rsp_q;

  assign slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;

  assign rd_en   = cmd_i.rd_home | cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_home ? SLOT_BITS'(home_q) : slot_next;
  assign wr_en   = cmd_i.clr_step | cmd_i.wr_entry;
  assign wr_addr = cmd_i.clr_step ? clr_q : slot_q;

  always_comb begin
    wr_data = '0;
    if (!cmd_i.clr_step) begin
      wr_data.occ     = 1'b1;
      wr_data.present = pres_q;
      wr_data.value   = val_q;
      wr_data.key     = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Item and probe registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= req_i.action;
      key_q  <= KEY_BITS'(req_i.key_token);
      val_q  <= req_i.value_present ? VALUE_BITS'(req_i.entry_value) : '0;
      pres_q <= req_i.value_present;
      home_q <= req_i.home_slot;
    end else if (cmd_i.reduce) begin
      home_q <= home_q - HOME_BITS'(TABLE_SLOTS);
    end
    if (cmd_i.rd_home) begin
      slot_q <= SLOT_BITS'(home_q);
      cnt_q  <= '0;
    end else if (cmd_i.rd_next) begin
      slot_q <= slot_next;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clr_last = (clr_q == LAST_SLOT);
  assign sts_o.home_ge  = (32'(home_q) >= TABLE_SLOTS);
  assign sts_o.action   = act_q;
  assign sts_o.occ      = rd_q.occ;
  assign sts_o.key_eq   = (rd_q.key == key_q);
  assign sts_o.cnt_last = (cnt_q == LAST_SLOT);

  // One-cycle result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.status      <= cmd_i.emit_status;
      rsp_q.slot_used   <= (cmd_i.emit_status == ST_OK) ? HOME_BITS'(slot_q) : '0;
      rsp_q.found_value <= cmd_i.emit_hit ? VAL_W'(rd_q.value) : '0;
      rsp_q.has_value   <= cmd_i.emit_hit & rd_q.present;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== design/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table: controller plus datapath.
//
//   channel   ports                  handshake
//   -------   --------------------   -----------------------------------------
//   request   start_i, req_i         item taken at clk edge with start_i & !busy_o
//   result    valid_o, rsp_o         one-cycle strobe, always taken
//
// After reset the slot memory is swept clear, one slot a cycle, over all
// TABLE_SLOTS (512) slots with busy_o high.
// An accepted item passes the home state, where a home slot at or above
// TABLE_SLOTS is folded down before its read, then the probe state, which
// probes P slots (1 to TABLE_SLOTS), one probe per cycle through the single
// read port of the slot memory, and emits the result strobe. busy_o drops in
// the cycle the result appears, so a new item can be taken then.
// Results cannot be stalled.
module linear_probe_hash_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lph_pkg::lph_req_t req_i,
  output logic              busy_o,
  output logic              valid_o,
  output lph_pkg::lph_rsp_t rsp_o
);
  import lph_pkg::*;

  lph_cmd_t cmd;
  lph_sts_t sts;

  // Sequence clearing, home fold and the probe walk
  lph_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold the item, the slot memory and the result register
  lph_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .sts_o   (sts),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

// ===== tb/lph_checker.sv =====
// Scoreboard for the linear probing hash table: mirrors the slot store and checks every result.
module lph_table_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  lph_pkg::lph_req_t req_i,
  input  logic              valid_i,
  input  lph_pkg::lph_rsp_t rsp_i,
  output int                errors_o,
  output int                pending_o
);
  import lph_pkg::*;

  localparam int REPORT_CAP = 40;

  bit                    slot_taken   [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   slot_key_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] slot_val_mem [TABLE_SLOTS];
  bit                    slot_has_val [TABLE_SLOTS];
  lph_rsp_t              awaited_rsp_q [$];
  int                    reported;

  // Walk the mirror table the way the block does and return its answer.
  function automatic lph_rsp_t apply_table_op(lph_req_t item);
    lph_rsp_t    rsp;
    int unsigned slot;
    bit          hit;
    rsp  = '0;
    hit  = 1'b0;
    slot = item.home_slot % TABLE_SLOTS;
    if (item.action == ACT_INSERT) begin
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (!slot_taken[slot]) begin
          hit = 1'b1;
          break;
        end
        slot = (slot + 1) % TABLE_SLOTS;
      end
      if (hit) begin
        slot_taken[slot]   = 1'b1;
        slot_key_mem[slot] = item.key_token[KEY_BITS-1:0];
        slot_val_mem[slot] = item.value_present ? item.entry_value[VALUE_BITS-1:0] : '0;
        slot_has_val[slot] = item.value_present;
        rsp.status         = ST_OK;
        rsp.slot_used      = HOME_BITS'(slot);
      end else begin
        rsp.status = ST_FULL;
      end
    end else begin
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (!slot_taken[slot]) break;
        if (slot_key_mem[slot] == item.key_token[KEY_BITS-1:0]) begin
          hit = 1'b1;
          break;
        end
        slot = (slot + 1) % TABLE_SLOTS;
      end
      if (hit) begin
        rsp.status      = ST_OK;
        rsp.slot_used   = HOME_BITS'(slot);
        rsp.found_value = slot_val_mem[slot];
        rsp.has_value   = slot_has_val[slot];
      end else begin
        rsp.status = ST_MISS;
      end
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lph_rsp_t want;
    if (!rst_ni) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      awaited_rsp_q.delete();
      errors_o  = 0;
      pending_o = 0;
      reported  = 0;
    end else begin
      // Retire the result first: it belongs to an item taken earlier.
      if (valid_i) begin
        if (awaited_rsp_q.size() == 0) begin
          errors_o++;
          if (reported < REPORT_CAP) begin
            reported++;
            $display("%0t: result with nothing expected: %0d/%0d/%h/%0b", $time,
                     rsp_i.status, rsp_i.slot_used, rsp_i.found_value, rsp_i.has_value);
          end
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_i !== want) begin
            errors_o++;
            if (reported < REPORT_CAP) begin
              reported++;
              $display({"%0t: status/slot/value/has_value expected %0d/%0d/%h/%0b",
                        " got %0d/%0d/%h/%0b"},
                       $time, want.status, want.slot_used, want.found_value, want.has_value,
                       rsp_i.status, rsp_i.slot_used, rsp_i.found_value, rsp_i.has_value);
            end
          end
        end
      end
      if (start_i && !busy_i) awaited_rsp_q.push_back(apply_table_op(req_i));
      pending_o = awaited_rsp_q.size();
    end
  end

endmodule

// ===== tb/linear_probe_hash_table_tb.sv =====
// Top of the hash table testbench: clock, reset, item stimulus and the final verdict.
module linear_probe_hash_table_tb;
  import lph_pkg::*;

  localparam int     RESET_CYCLES = 8;
  localparam int     RANDOM_ITEMS = 1235;
  // Last stretch: no idling, heavier insert mix so the table fills up.
  localparam int     QUIET_TAIL   = 200;
  localparam int     DRAIN_CYCLES = 16;
  // Worst case is about 1250 items each walking every slot, plus the
  // clearing sweep; allow several times that.
  localparam longint CYCLE_LIMIT  = 3_000_000;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  lph_req_t req_i;
  logic     busy_o;
  logic     valid_o;
  lph_rsp_t rsp_o;

  int     errors;
  int     pending;
  longint cycle_count;

  // Keys already inserted, with their home slots, so lookups can chase them.
  logic [KEY_W-1:0]     known_keys  [$];
  logic [HOME_BITS-1:0] known_homes [$];

  linear_probe_hash_table uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  lph_table_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .req_i     (req_i),
    .valid_i   (valid_o),
    .rsp_i     (rsp_o),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic lph_req_t make_req(logic act, logic [KEY_W-1:0] key,
                                        logic [HOME_BITS-1:0] home,
                                        logic [VAL_W-1:0] value, logic present);
    lph_req_t item;
    item.action        = act;
    item.key_token     = key;
    item.home_slot     = home;
    item.entry_value   = value;
    item.value_present = present;
    return item;
  endfunction

  // Crowd the top of the table (forces wraps) and the bottom (long clusters).
  function automatic logic [HOME_BITS-1:0] pick_home();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return HOME_BITS'($urandom_range(TABLE_SLOTS - 1, TABLE_SLOTS - 12));
    if (r < 35) return HOME_BITS'($urandom_range(7));
    return HOME_BITS'($urandom_range(TABLE_SLOTS - 1));
  endfunction

  function automatic lph_req_t random_item(int unsigned insert_pct);
    lph_req_t    item;
    int unsigned idx;
    bit          reuse;
    item.action        = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_LOOKUP;
    item.key_token     = $urandom();
    item.home_slot     = pick_home();
    item.entry_value   = $urandom();
    item.value_present = 1'($urandom_range(1));
    // Lookups mostly chase a stored key; a few inserts repeat one.
    if (item.action == ACT_LOOKUP) reuse = $urandom_range(99) < 70;
    else reuse = $urandom_range(99) < 10;
    if (reuse && known_keys.size() > 0) begin
      idx            = $urandom_range(known_keys.size() - 1);
      item.key_token = known_keys[idx];
      if ($urandom_range(9) != 0) item.home_slot = known_homes[idx];
    end
    return item;
  endfunction

  // Present one item and hold it until the edge that takes it.
  task automatic issue_item(input lph_req_t item);
    if (item.action == ACT_INSERT) begin
      known_keys.push_back(item.key_token);
      known_homes.push_back(item.home_slot);
    end
    start_i <= 1'b1;
    req_i   <= item;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin : stimulus
    bit idle_ok;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cycle_count = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extreme keys and values, wrap past the last
    // slot, duplicate keys, hits with and without a value, misses on an
    // empty slot and after a probe run. The block sweeps its store first.
    issue_item(make_req(ACT_LOOKUP, 32'h0000_0000, 9'd0,   32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_INSERT, 32'hFFFF_FFFF, 9'd511, 32'hFFFF_FFFF, 1'b1));
    issue_item(make_req(ACT_INSERT, 32'h0000_0000, 9'd511, 32'hFFFF_FFFF, 1'b0));
    issue_item(make_req(ACT_INSERT, 32'h0000_0000, 9'd0,   32'h1234_5678, 1'b1));
    issue_item(make_req(ACT_LOOKUP, 32'h0000_0000, 9'd511, 32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, 9'd511, 32'hFFFF_FFFF, 1'b1));
    issue_item(make_req(ACT_LOOKUP, 32'h0000_0000, 9'd1,   32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_LOOKUP, 32'h0000_0005, 9'd511, 32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, 9'd0,   32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_INSERT, 32'hA5A5_A5A5, 9'd256, 32'h5A5A_5A5A, 1'b1));
    issue_item(make_req(ACT_INSERT, 32'h5A5A_5A5A, 9'd256, 32'hA5A5_A5A5, 1'b1));
    issue_item(make_req(ACT_LOOKUP, 32'h5A5A_5A5A, 9'd256, 32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_LOOKUP, 32'h5A5A_5A5A, 9'd255, 32'h0000_0000, 1'b0));
    issue_item(make_req(ACT_INSERT, 32'h0000_0001, 9'd1,   32'h0000_0000, 1'b1));
    issue_item(make_req(ACT_LOOKUP, 32'h0000_0001, 9'd0,   32'h0000_0000, 1'b0));

    // Random: the table fills gradually, then the tail pushes it to full so
    // inserts report table full and unknown keys walk every slot.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_ok = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i % 150) < 100);
      if (idle_ok && $urandom_range(99) < 30) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      issue_item(random_item((i < RANDOM_ITEMS - QUIET_TAIL) ? 40 : 70));
    end
    start_i <= 1'b0;

    // Drain: sample on the falling edge, clear of the checker's updates.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lph_pkg.sv
design/lph_ctrl.sv
design/lph_dp.sv
design/linear_probe_hash_table.sv
tb/lph_checker.sv
tb/linear_probe_hash_table_tb.sv
